### sv/pitch_ratio_to_semitone_cents_core_macros.svh
// Assertion macros used by the port-level checker file of the pitch ratio core.
`ifndef PITCH_RATIO_TO_SEMITONE_CENTS_CORE_MACROS_SVH
`define PITCH_RATIO_TO_SEMITONE_CENTS_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PRTSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PRTSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/prtsc_pkg.sv
// Shared constants and stage types of the pitch ratio to semitone and cents core.
package prtsc_pkg;

    // Fractional bits of the log; the working precision carries a wide guard.
    localparam int LOG_FRAC_BITS = 24;
    localparam int WORK_BITS     = LOG_FRAC_BITS + 26;

    // Field widths.
    localparam int BYTE_BITS   = 8;
    localparam int KEY_BITS    = 7;
    localparam int CENTS_BITS  = 7;
    localparam int RATIO_BITS  = 2 * BYTE_BITS + 1;
    localparam int COARSE_BITS = 4;

    // Mantissa in Q1.62, split into a high and a low half for squaring.
    localparam int MANT_BITS    = 63;
    localparam int MANT_LO_BITS = 32;
    localparam int MANT_HI_BITS = MANT_BITS - MANT_LO_BITS;
    localparam int SQ_BITS      = 2 * MANT_BITS;

    // Width of the magnitude of twelve times the log.
    localparam int MAG_BITS = WORK_BITS + 4;

    // Arithmetic constants.
    localparam logic [KEY_BITS-1:0] ROOT_BASE   = KEY_BITS'(69);
    localparam logic [6:0]          CENTS_SCALE = 7'd100;

    // Running state of the log pipeline.
    typedef struct packed {
        logic [MANT_BITS-1:0] mant;
        logic [WORK_BITS-1:0] acc;
        logic                 low;
    } t_log_state;

    // Partial products of one squaring step.
    typedef struct packed {
        logic [2*MANT_HI_BITS-1:0]          p_hh;
        logic [MANT_HI_BITS+MANT_LO_BITS-1:0] p_hl;
        logic [2*MANT_LO_BITS-1:0]          p_ll;
        logic [WORK_BITS-1:0]               acc;
        logic                               low;
    } t_log_part;

endpackage

### sv/prtsc_ifs.sv
// Stream interfaces for the tuning input and the pitch result of the core.
interface prtsc_tuning_if;
    logic                                valid;
    logic                                ready;
    logic [prtsc_pkg::BYTE_BITS-1:0]     tuning_byte;
    logic [prtsc_pkg::BYTE_BITS-1:0]     tuning_fraction;

    modport source (output valid, output tuning_byte, output tuning_fraction, input ready);
    modport sink   (input valid, input tuning_byte, input tuning_fraction, output ready);
endinterface

interface prtsc_pitch_if;
    logic                                  valid;
    logic                                  ready;
    logic [prtsc_pkg::KEY_BITS-1:0]        root_key;
    logic signed [prtsc_pkg::CENTS_BITS-1:0] cents;

    modport source (output valid, output root_key, output cents, input ready);
    modport sink   (input valid, input root_key, input cents, output ready);
endinterface

### sv/prtsc_front.sv
// Input stage: forms the Q1.16 ratio and the normalized log mantissa.
module prtsc_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [prtsc_pkg::BYTE_BITS-1:0]  i_tuning_byte,
    input  logic [prtsc_pkg::BYTE_BITS-1:0]  i_tuning_fraction,
    input  logic                             i_two_byte_tuning,
    output logic                             o_valid,
    input  logic                             i_ready,
    output prtsc_pkg::t_log_state            o_state
);

    logic                                w_en;
    logic                                w_low;
    logic [prtsc_pkg::BYTE_BITS-1:0]     w_frac;
    logic [prtsc_pkg::RATIO_BITS-1:0]    w_ratio;
    prtsc_pkg::t_log_state               n_state;
    logic                                r_valid;
    prtsc_pkg::t_log_state               r_state;

    // The stage takes a new transaction when empty or when its content moves on.
    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    // A byte with the top bit set is a ratio below one; otherwise one is added.
    always_comb begin
        w_low   = i_tuning_byte[prtsc_pkg::BYTE_BITS-1];
        w_frac  = i_two_byte_tuning ? i_tuning_fraction : '0;
        w_ratio = {~w_low, i_tuning_byte, w_frac};
        n_state.acc = '0;
        n_state.low = w_low;
        if (w_low) begin
            n_state.mant = {w_ratio[prtsc_pkg::RATIO_BITS-2:0],
                            {(prtsc_pkg::MANT_BITS-prtsc_pkg::RATIO_BITS+1){1'b0}}};
        end else begin
            n_state.mant = {w_ratio,
                            {(prtsc_pkg::MANT_BITS-prtsc_pkg::RATIO_BITS){1'b0}}};
        end
    end

    // Stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

### sv/prtsc_log_step.sv
// One bit of the log by squaring: a partial product stage and a normalize stage.
module prtsc_log_step (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  prtsc_pkg::t_log_state i_state,
    output logic                  o_valid,
    input  logic                  i_ready,
    output prtsc_pkg::t_log_state o_state
);

    logic                                      w_en_a;
    logic                                      w_en_b;
    logic [prtsc_pkg::MANT_HI_BITS-1:0]        w_hi;
    logic [prtsc_pkg::MANT_LO_BITS-1:0]        w_lo;
    prtsc_pkg::t_log_part                      n_part;
    logic                                      r_a_valid;
    prtsc_pkg::t_log_part                      r_part;
    logic [prtsc_pkg::SQ_BITS-1:0]             w_square;
    logic [prtsc_pkg::MANT_BITS:0]             w_top;
    logic                                      w_bit;
    prtsc_pkg::t_log_state                     n_state;
    logic                                      r_b_valid;
    prtsc_pkg::t_log_state                     r_state;

    // Each register stage moves when empty or when the one after it moves.
    assign w_en_b  = !r_b_valid || i_ready;
    assign w_en_a  = !r_a_valid || w_en_b;
    assign o_ready = w_en_a;

    // Three partial products of the square, each at most 32 by 32 bits.
    always_comb begin
        w_hi        = i_state.mant[prtsc_pkg::MANT_BITS-1:prtsc_pkg::MANT_LO_BITS];
        w_lo        = i_state.mant[prtsc_pkg::MANT_LO_BITS-1:0];
        n_part.p_hh = (2*prtsc_pkg::MANT_HI_BITS)'(w_hi) * (2*prtsc_pkg::MANT_HI_BITS)'(w_hi);
        n_part.p_hl = (prtsc_pkg::MANT_HI_BITS+prtsc_pkg::MANT_LO_BITS)'(w_hi)
                    * (prtsc_pkg::MANT_HI_BITS+prtsc_pkg::MANT_LO_BITS)'(w_lo);
        n_part.p_ll = (2*prtsc_pkg::MANT_LO_BITS)'(w_lo) * (2*prtsc_pkg::MANT_LO_BITS)'(w_lo);
        n_part.acc  = i_state.acc;
        n_part.low  = i_state.low;
    end

    // Sum the partial products, truncate to Q2.62 and renormalize into [1, 2).
    always_comb begin
        w_square = {r_part.p_hh, {(2*prtsc_pkg::MANT_LO_BITS){1'b0}}}
                 + prtsc_pkg::SQ_BITS'({r_part.p_hl, {(prtsc_pkg::MANT_LO_BITS+1){1'b0}}})
                 + prtsc_pkg::SQ_BITS'(r_part.p_ll);
        w_top    = w_square[prtsc_pkg::SQ_BITS-1:prtsc_pkg::MANT_BITS-1];
        w_bit    = w_top[prtsc_pkg::MANT_BITS];
        n_state.mant = w_bit ? w_top[prtsc_pkg::MANT_BITS:1]
                             : w_top[prtsc_pkg::MANT_BITS-1:0];
        n_state.acc  = {r_part.acc[prtsc_pkg::WORK_BITS-2:0], w_bit};
        n_state.low  = r_part.low;
    end

    // Valid bits of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_en_a) begin
                r_a_valid <= i_valid;
            end
            if (w_en_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    // Payload of both stages.
    always_ff @(posedge i_clk) begin
        if (w_en_a && i_valid) begin
            r_part <= n_part;
        end
        if (w_en_b && r_a_valid) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_b_valid;
    assign o_state = r_state;

endmodule

### sv/prtsc_back.sv
// Output stages: scale the log by twelve, split semitones and cents, and hold the result.
module prtsc_back (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  prtsc_pkg::t_log_state                   i_state,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [prtsc_pkg::KEY_BITS-1:0]          o_root_key,
    output logic signed [prtsc_pkg::CENTS_BITS-1:0] o_cents
);

    localparam int W = prtsc_pkg::WORK_BITS;

    logic                                   w_en1;
    logic                                   w_en2;
    logic                                   w_en3;
    logic                                   w_en4;
    logic [W:0]                             n_dist;
    logic                                   r_v1;
    logic [W:0]                             r_dist;
    logic                                   r_low1;
    logic [prtsc_pkg::MAG_BITS-1:0]         n_mag;
    logic                                   r_v2;
    logic [prtsc_pkg::MAG_BITS-1:0]         r_mag;
    logic                                   r_low2;
    logic [W-1:0]                           w_frac;
    logic [W-1:0]                           w_frac_neg;
    logic [prtsc_pkg::COARSE_BITS-1:0]      n_coarse;
    logic [W-1:0]                           n_fmag;
    logic                                   r_v3;
    logic [prtsc_pkg::COARSE_BITS-1:0]      r_coarse;
    logic [W-1:0]                           r_fmag;
    logic                                   r_fneg;
    logic                                   r_low3;
    logic [W+6:0]                           w_prod;
    logic [prtsc_pkg::CENTS_BITS-1:0]       w_cm;
    logic [prtsc_pkg::KEY_BITS-1:0]         n_root;
    logic [prtsc_pkg::CENTS_BITS-1:0]       n_cents;
    logic                                   r_v4;
    logic [prtsc_pkg::KEY_BITS-1:0]         r_root;
    logic [prtsc_pkg::CENTS_BITS-1:0]       r_cents;

    // Stage enables; the last stage is the output register.
    assign w_en4   = !r_v4 || i_ready;
    assign w_en3   = !r_v3 || w_en4;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    // Distance of the log from zero: below one the exponent of minus one is folded in.
    assign n_dist = i_state.low ? ({1'b1, {W{1'b0}}} - {1'b0, i_state.acc})
                                : {1'b0, i_state.acc};

    // Twelve times the distance as eight plus four times.
    assign n_mag = prtsc_pkg::MAG_BITS'({r_dist, 3'b000})
                 + prtsc_pkg::MAG_BITS'({r_dist, 2'b00});

    // Split into semitones and a fraction; a fraction of one half or more rounds up.
    always_comb begin
        w_frac     = r_mag[W-1:0];
        w_frac_neg = ~w_frac + {{(W-1){1'b0}}, 1'b1};
        n_coarse   = r_mag[prtsc_pkg::MAG_BITS-1:W]
                   + {{(prtsc_pkg::COARSE_BITS-1){1'b0}}, w_frac[W-1]};
        n_fmag     = w_frac[W-1] ? w_frac_neg : w_frac;
    end

    // Cents are the fraction times one hundred, truncated; the key moves opposite the sign.
    always_comb begin
        w_prod  = (W+7)'(r_fmag) * (W+7)'(prtsc_pkg::CENTS_SCALE);
        w_cm    = w_prod[W+6:W];
        n_cents = r_fneg ? (~w_cm + {{(prtsc_pkg::CENTS_BITS-1){1'b0}}, 1'b1}) : w_cm;
        n_root  = r_low3
                ? prtsc_pkg::ROOT_BASE + prtsc_pkg::KEY_BITS'(r_coarse)
                : prtsc_pkg::ROOT_BASE - prtsc_pkg::KEY_BITS'(r_coarse);
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            r_dist <= n_dist;
            r_low1 <= i_state.low;
        end
        if (w_en2 && r_v1) begin
            r_mag  <= n_mag;
            r_low2 <= r_low1;
        end
        if (w_en3 && r_v2) begin
            r_coarse <= n_coarse;
            r_fmag   <= n_fmag;
            r_fneg   <= r_low2 ^ w_frac[W-1];
            r_low3   <= r_low2;
        end
        if (w_en4 && r_v3) begin
            r_root  <= n_root;
            r_cents <= n_cents;
        end
    end

    assign o_valid    = r_v4;
    assign o_root_key = r_root;
    assign o_cents    = $signed(r_cents);

endmodule

### sv/pitch_ratio_to_semitone_cents_core.sv
// Top level of the pitch ratio to semitone and cents core.
//
//   Channel   Direction  Handshake     Payload
//   i_tuning  in         valid/ready   tuning_byte[7:0], tuning_fraction[7:0]
//   o_pitch   out        valid/ready   root_key[6:0], cents[6:0] signed
//   i_cfg_*   in         write enable  two_byte_tuning (1 bit)
//
// One transaction enters per cycle unless the output stalls the pipeline; the depth
// is set by the log by squaring, one result bit per two-stage step with the partial
// products of the 63-bit square registered.
// Reset clears every stage valid bit and sets two_byte_tuning to one.
// Each stage holds while full and blocked downstream; empty stages keep filling, so
// input is taken while a finished result waits at the output register.
module pitch_ratio_to_semitone_cents_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic            i_cfg_wr_data,
    prtsc_tuning_if.sink    i_tuning,
    prtsc_pitch_if.source   o_pitch
);

    localparam int STEPS = prtsc_pkg::WORK_BITS;

    logic                   r_two_byte_tuning;
    logic                   w_valid [STEPS+1];
    logic                   w_ready [STEPS+1];
    prtsc_pkg::t_log_state  w_state [STEPS+1];

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two_byte_tuning <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_two_byte_tuning <= i_cfg_wr_data;
        end
    end

    // Ratio and mantissa formation.
    prtsc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_tuning.valid),
        .o_ready           (i_tuning.ready),
        .i_tuning_byte     (i_tuning.tuning_byte),
        .i_tuning_fraction (i_tuning.tuning_fraction),
        .i_two_byte_tuning (r_two_byte_tuning),
        .o_valid           (w_valid[0]),
        .i_ready           (w_ready[0]),
        .o_state           (w_state[0])
    );

    // Chain of log steps, one result bit each.
    for (genvar g = 0; g < STEPS; g++) begin : g_step
        prtsc_log_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_state (w_state[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_state (w_state[g+1])
        );
    end

    // Scaling, split and output register.
    prtsc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid[STEPS]),
        .o_ready    (w_ready[STEPS]),
        .i_state    (w_state[STEPS]),
        .o_valid    (o_pitch.valid),
        .i_ready    (o_pitch.ready),
        .o_root_key (o_pitch.root_key),
        .o_cents    (o_pitch.cents)
    );

endmodule

### sv/prtsc_checker.sv
// Port-level checks of the pitch ratio core and their binding to the top level.
`include "pitch_ratio_to_semitone_cents_core_macros.svh"

module prtsc_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_out_valid,
    input  logic                                    i_out_ready,
    input  logic [prtsc_pkg::KEY_BITS-1:0]          i_root_key,
    input  logic signed [prtsc_pkg::CENTS_BITS-1:0] i_cents
);

    // A result transaction that is not taken stays offered with the same payload.
    `PRTSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "output valid dropped before the transaction completed")
    `PRTSC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_root_key) && $stable(i_cents), "output payload changed while stalled")

    // The semitone split keeps the key and cents in their ranges.
    `PRTSC_ASSERT_NOW(a_key_range, i_clk, i_rst_n, i_out_valid, (i_root_key >= 7'd57) && (i_root_key <= 7'd81), "root key out of range")
    `PRTSC_ASSERT_NOW(a_cents_range, i_clk, i_rst_n, i_out_valid, (i_cents >= -(7'sd50)) && (i_cents <= 7'sd50), "cents out of range")

endmodule

bind pitch_ratio_to_semitone_cents_core prtsc_checker u_prtsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_pitch.valid),
    .i_out_ready (o_pitch.ready),
    .i_root_key  (o_pitch.root_key),
    .i_cents     (o_pitch.cents)
);

### tb/prtsc_pitch_checker.sv
// Checker that predicts and compares the pitch results of the pitch ratio core.
`timescale 1ns / 100ps

module prtsc_pitch_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_wr_en,
    input  logic    i_cfg_wr_data,
    prtsc_tuning_if tuning_mon,
    prtsc_pitch_if  pitch_mon,
    output int      o_fail_count,
    output int      o_pending,
    output int      o_checked
);

    localparam int          W           = prtsc_pkg::WORK_BITS;
    localparam logic [63:0] LOG_ONE     = 64'd1 << W;
    localparam logic [63:0] LOG_HALF    = 64'd1 << (W - 1);
    localparam logic [63:0] UNITY_RATIO = 64'd65536;
    localparam int          UNITY_KEY   = 69;

    // One predicted result, kept with the transaction that caused it.
    typedef struct packed {
        logic [prtsc_pkg::BYTE_BITS-1:0]  tuning_byte;
        logic [prtsc_pkg::BYTE_BITS-1:0]  tuning_fraction;
        logic [prtsc_pkg::KEY_BITS-1:0]   root_key;
        logic [prtsc_pkg::CENTS_BITS-1:0] cents;
    } t_pitch_expect;

    t_pitch_expect expected_pitch_q[$];
    logic          use_fraction = 1'b1;
    int            fail_count   = 0;
    int            pending      = 0;
    int            checked      = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_checked    = checked;

    // Prints one line for each mismatch and counts it.
    task automatic report_mismatch(input string what);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Appends one prediction at the tail of the expected queue.
    task automatic enqueue_expected(input t_pitch_expect item);
        expected_pitch_q = {expected_pitch_q, item};
    endtask

    // Log base two of a Q1.62 mantissa in [1, 2) by repeated squaring, truncated.
    function automatic logic [W-1:0] log2_of_mantissa(input logic [63:0] mant);
        logic [63:0]  m;
        logic [127:0] sq;
        logic [W-1:0] acc;
        int           i;
        m   = mant;
        acc = '0;
        for (i = 0; i < W; i++) begin
            sq  = {64'd0, m} * {64'd0, m};
            m   = sq[125:62];
            acc = {acc[W-2:0], 1'b0};
            if (m[63]) begin
                acc[0] = 1'b1;
                m      = m >> 1;
            end
        end
        return acc;
    endfunction

    // Root key and cents for one tuning transaction.
    function automatic t_pitch_expect predict_pitch(input logic [7:0] t_byte,
                                                    input logic [7:0] t_frac,
                                                    input logic       frac_on);
        logic [63:0]   ratio, lg, mag, coarse, frac_part, frac_mag, cents_mag;
        logic          neg, frac_neg;
        int            semis, key;
        t_pitch_expect res;
        ratio = t_byte[7] ? {48'd0, t_byte, 8'd0} : UNITY_RATIO + {48'd0, t_byte, 8'd0};
        if (frac_on) begin
            ratio = ratio + {56'd0, t_frac};
        end

        // Ratios below one are taken an octave up and the log is reflected.
        if (ratio >= UNITY_RATIO) begin
            lg  = 64'(log2_of_mantissa(ratio << 46));
            mag = 64'd12 * lg;
            neg = 1'b0;
        end else begin
            lg  = 64'(log2_of_mantissa(ratio << 47));
            mag = 64'd12 * (LOG_ONE - lg);
            neg = (mag != 64'd0);
        end

        // A fraction of half a semitone or more rolls into the next semitone.
        coarse    = mag >> W;
        frac_part = mag & (LOG_ONE - 64'd1);
        frac_neg  = neg;
        if (frac_part >= LOG_HALF) begin
            coarse   = coarse + 64'd1;
            frac_mag = LOG_ONE - frac_part;
            frac_neg = !neg;
        end else begin
            frac_mag = frac_part;
        end

        // Cents are the fraction times one hundred, truncated.
        cents_mag = ((frac_mag >> 32) * 64'd100 +
                     (((frac_mag & 64'hffff_ffff) * 64'd100) >> 32)) >> (W - 32);

        semis = int'(coarse[7:0]);
        if (neg) begin
            semis = -semis;
        end
        key = UNITY_KEY - semis;

        res.tuning_byte     = t_byte;
        res.tuning_fraction = t_frac;
        res.root_key        = prtsc_pkg::KEY_BITS'(key);
        // A zero cents value never carries a sign.
        if (frac_neg && cents_mag != 64'd0) begin
            res.cents = prtsc_pkg::CENTS_BITS'(64'd128 - cents_mag);
        end else begin
            res.cents = prtsc_pkg::CENTS_BITS'(cents_mag);
        end
        return res;
    endfunction

    // Watch both channels and the register port at every rising edge.
    always @(posedge i_clk) begin
        t_pitch_expect oldest;
        if (!i_rst_n) begin
            use_fraction = 1'b1;
        end else begin
            // Every accepted tuning transaction causes exactly one result; it sees
            // the register value from before a write at the same edge.
            if (tuning_mon.valid && tuning_mon.ready) begin
                enqueue_expected(predict_pitch(tuning_mon.tuning_byte,
                                               tuning_mon.tuning_fraction,
                                               use_fraction));
            end

            if (i_cfg_wr_en) begin
                use_fraction = i_cfg_wr_data;
            end

            // Compare each accepted result with the oldest prediction.
            if (pitch_mon.valid && pitch_mon.ready) begin
                if (expected_pitch_q.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected: key %0d cents %0d",
                                              pitch_mon.root_key, $signed(pitch_mon.cents)));
                end else begin
                    oldest = expected_pitch_q.pop_front();
                    checked++;
                    if (pitch_mon.root_key !== oldest.root_key) begin
                        report_mismatch($sformatf("t=%02h f=%02h root_key %0d, expected %0d",
                                                  oldest.tuning_byte, oldest.tuning_fraction,
                                                  pitch_mon.root_key, oldest.root_key));
                    end
                    if (pitch_mon.cents !== oldest.cents) begin
                        report_mismatch($sformatf("t=%02h f=%02h cents %0d, expected %0d",
                                                  oldest.tuning_byte, oldest.tuning_fraction,
                                                  $signed(pitch_mon.cents),
                                                  $signed(oldest.cents)));
                    end
                end
            end
            pending = expected_pitch_q.size();
        end
    end

endmodule

### tb/pitch_ratio_to_semitone_cents_core_tb.sv
// Testbench top that drives the pitch ratio core and reports the verdict.
`timescale 1ns / 100ps

module pitch_ratio_to_semitone_cents_core_tb;

    localparam int   CYCLE_LIMIT     = 200000;
    localparam int   DRAIN_CYCLES    = 150;
    localparam int   HOLD_OFF_CYCLES = 400;
    localparam logic TWO_BYTE_OFF    = 1'b0;
    localparam logic TWO_BYTE_ON     = 1'b1;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    prtsc_tuning_if tuning_if ();
    prtsc_pitch_if  pitch_if ();

    int fail_count;
    int pending_count;
    int checked_count;
    int sent_count     = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_left  = 0;

    pitch_ratio_to_semitone_cents_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_tuning     (tuning_if),
        .o_pitch      (pitch_if)
    );

    prtsc_pitch_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .tuning_mon   (tuning_if),
        .pitch_mon    (pitch_if),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    always #2 i_clk = ~i_clk;

    // Give up on a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results pending.",
                     cycle_count, pending_count);
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: random stalls, or a counted hold-off when one is requested.
    initial begin
        pitch_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_left > 0) begin
                pitch_if.ready <= 1'b0;
                hold_off_left--;
            end else begin
                pitch_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offers one tuning transaction, idling first at the current rate.
    task automatic send_tuning(input logic [7:0] t_byte, input logic [7:0] t_frac);
        while ($urandom_range(99) < send_idle_pct) begin
            tuning_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        tuning_if.valid           <= 1'b1;
        tuning_if.tuning_byte     <= t_byte;
        tuning_if.tuning_fraction <= t_frac;
        @(posedge i_clk);
        while (!tuning_if.ready) begin
            @(posedge i_clk);
        end
        sent_count++;
    endtask

    // Random transactions, with some weight on the two ratio ranges' edges.
    task automatic send_random(input int count);
        logic [7:0] t_byte;
        logic [7:0] t_frac;
        int         k;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(9))
                0:       t_byte = $urandom_range(1) ? 8'h7f : 8'h80;
                1:       t_byte = $urandom_range(1) ? 8'h00 : 8'hff;
                default: t_byte = 8'($urandom);
            endcase
            t_frac = 8'($urandom);
            send_tuning(t_byte, t_frac);
        end
    endtask

    // Stops offering and waits until every predicted result has been seen.
    task automatic wait_for_results();
        tuning_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_two_byte(input logic value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        send_random(count);
        wait_for_results();
    endtask

    // Main sequence.
    initial begin
        tuning_if.valid           <= 1'b0;
        tuning_if.tuning_byte     <= '0;
        tuning_if.tuning_fraction <= '0;
        cfg_wr_en                 <= 1'b0;
        cfg_wr_data               <= 1'b0;
        i_rst_n                   <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Corners with the fraction byte in use, as after reset.
        send_tuning(8'h00, 8'h00);  // unity ratio
        send_tuning(8'h80, 8'h00);  // exact octave down
        send_tuning(8'h7f, 8'hff);  // largest ratio
        send_tuning(8'h7f, 8'h00);
        send_tuning(8'hff, 8'hff);  // just below unity: cents truncates to zero
        send_tuning(8'hff, 8'h00);
        send_tuning(8'h80, 8'hff);
        send_tuning(8'h00, 8'hff);
        send_tuning(8'h00, 8'h01);
        send_tuning(8'h01, 8'h00);
        send_tuning(8'h40, 8'h00);
        send_tuning(8'hc0, 8'h00);
        send_tuning(8'hb5, 8'h05);
        send_tuning(8'h0f, 8'h00);
        send_tuning(8'h10, 8'h00);
        send_tuning(8'he0, 8'h00);
        send_tuning(8'hfe, 8'h80);
        send_tuning(8'h55, 8'haa);
        wait_for_results();

        // Same corners with the fraction byte forced to zero.
        write_two_byte(TWO_BYTE_OFF);
        send_tuning(8'h00, 8'hff);
        send_tuning(8'h80, 8'hff);
        send_tuning(8'h7f, 8'hff);
        send_tuning(8'hff, 8'haa);
        wait_for_results();
        write_two_byte(TWO_BYTE_ON);

        // Random traffic under different idling mixes.
        run_phase(0, 0, 100);
        run_phase(84, 0, 90);
        run_phase(0, 84, 90);
        run_phase(23, 23, 120);

        // Long output hold-off while the input keeps pushing.
        hold_off_left = HOLD_OFF_CYCLES;
        run_phase(0, 0, 160);

        // Older single-byte format, then back to the default.
        write_two_byte(TWO_BYTE_OFF);
        run_phase(23, 23, 50);
        write_two_byte(TWO_BYTE_ON);
        run_phase(0, 0, 20);

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d tuning transactions and checked %0d pitch results in %0d cycles.",
                 sent_count, checked_count, cycle_count);
        $display("Covered ratio corners, both fraction modes, idle and stall mixes, %s",
                 "and a long output hold-off.");
        if (pending_count != 0) begin
            $display("%0d expected pitch results never arrived.", pending_count);
        end
        if (fail_count == 0 && pending_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
